### design/assert_macros.svh
// assertion macros shared by the png chunk validator rtl
// depends on nothing; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check sampled on the rising clock, off while reset is high
`define PCV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// same-cycle implication check, off while reset is high
`define PCV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check, off while reset is high
`define PCV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pngcsv_pkg.sv
// types, codes and small decode functions of the png chunk validator
// depends on nothing; used by the parser, the record queue and the top level
`default_nettype none

package pngcsv_pkg;

  typedef enum logic [2:0] {
    PH_SIG       = 3'd0,
    PH_IHDR_HDR  = 3'd1,
    PH_IHDR_DATA = 3'd2,
    PH_HDR       = 3'd3,
    PH_SKIP      = 3'd4,
    PH_DONE      = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_IHDR    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL  = 3'd1;
  localparam logic [2:0] ST_BAD_SIG    = 3'd2;
  localparam logic [2:0] ST_NO_IHDR    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_NO_DATA    = 3'd5;
  localparam logic [2:0] ST_NO_IEND    = 3'd6;
  localparam logic [2:0] ST_BAD_IHDR   = 3'd7;

  localparam logic [2:0] COLOR_GRAY       = 3'd0;
  localparam logic [2:0] COLOR_TRUE       = 3'd1;
  localparam logic [2:0] COLOR_INDEXED    = 3'd2;
  localparam logic [2:0] COLOR_GRAY_ALPHA = 3'd3;
  localparam logic [2:0] COLOR_TRUE_ALPHA = 3'd4;
  localparam logic [2:0] COLOR_INVALID    = 3'd5;

  localparam logic [1:0] ILACE_NONE    = 2'd0;
  localparam logic [1:0] ILACE_ADAM7   = 2'd1;
  localparam logic [1:0] ILACE_INVALID = 2'd2;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam int unsigned IHDR_LEN = 13;
  localparam logic [31:0] IHDR_LEN_W = 32'd13;
  localparam logic [3:0]  IHDR_LAST_POS = 4'd12;
  localparam logic [3:0]  IHDR_LEN_POS  = 4'd13;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] chunk_length;
    logic [31:0] chunk_tag;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  pixel_depth;
    logic [2:0]  color_class;
    logic [1:0]  interlace_class;
    logic        compression_ok;
    logic        filter_ok;
    logic [2:0]  status;
    logic        last_of_run;
  } rec_t;

  // up to two records per byte: a is the chunk or ihdr record, b the verdict
  typedef struct packed {
    logic a_valid;
    rec_t a;
    logic b_valid;
    rec_t b;
  } push_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4E;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0D;
      3'd5:    v = 8'h0A;
      3'd6:    v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] color_of(input logic [7:0] c);
    logic [2:0] v;
    case (c)
      8'd0:    v = COLOR_GRAY;
      8'd2:    v = COLOR_TRUE;
      8'd3:    v = COLOR_INDEXED;
      8'd4:    v = COLOR_GRAY_ALPHA;
      8'd6:    v = COLOR_TRUE_ALPHA;
      default: v = COLOR_INVALID;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] interlace_of(input logic [7:0] c);
    logic [1:0] v;
    case (c)
      8'd0:    v = ILACE_NONE;
      8'd1:    v = ILACE_ADAM7;
      default: v = ILACE_INVALID;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### design/png_chunk_stream_validator_top.sv
// top level of the png chunk stream validator: parser feeding a record queue
// depends on pngcsv_pkg, pngcsv_parser and pngcsv_queue
// a byte's records are written into the queue at the edge that accepts the byte
// throughput: one byte per cycle while byte_stall is low; the end_of_file byte may
//   give two records, which leave one per cycle through the queue while rec_stall is low
// byte_stall rises while the queue has fewer than two free slots
// reset: synchronous, clears the parser to the signature phase and empties
//   the queue; after each end_of_file byte the parser also restarts
`default_nettype none

module png_chunk_stream_validator_top #(
  // record queue depth, at least two
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte request channel
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_file,
  // record request channel
  output logic             rec_valid,
  input  wire logic        rec_stall,
  output logic [1:0]       record_kind,
  output logic [31:0]      chunk_length,
  output logic [31:0]      chunk_tag,
  output logic [31:0]      image_width,
  output logic [31:0]      image_height,
  output logic [7:0]       pixel_depth,
  output logic [2:0]       color_class,
  output logic [1:0]       interlace_class,
  output logic             compression_ok,
  output logic             filter_ok,
  output logic [2:0]       status,
  output logic             last_of_run
);

  logic               byte_accept;
  logic               rec_pop;
  logic               full_for_two;
  pngcsv_pkg::push_t  push;
  pngcsv_pkg::rec_t   head;

  // a request is taken only when two slots are free, so a byte never
  // has to wait halfway through its records
  assign byte_stall  = full_for_two;
  assign byte_accept = byte_valid && !byte_stall;
  assign rec_pop     = rec_valid && !rec_stall;

  // all per-byte work: signature compare, shift-in of length and type,
  // data skip counter and ihdr field capture, verdict on the last byte
  pngcsv_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (byte_accept),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .push        (push)
  );

  // result register bank; decouples the record side from the byte side
  pngcsv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_en      (byte_accept),
    .pop          (rec_pop),
    .full_for_two (full_for_two),
    .head_valid   (rec_valid),
    .head         (head)
  );

  // head record fanned out to the payload ports
  assign record_kind     = head.record_kind;
  assign chunk_length    = head.chunk_length;
  assign chunk_tag       = head.chunk_tag;
  assign image_width     = head.image_width;
  assign image_height    = head.image_height;
  assign pixel_depth     = head.pixel_depth;
  assign color_class     = head.color_class;
  assign interlace_class = head.interlace_class;
  assign compression_ok  = head.compression_ok;
  assign filter_ok       = head.filter_ok;
  assign status          = head.status;
  assign last_of_run     = head.last_of_run;

endmodule

`default_nettype wire

### design/pngcsv_parser.sv
// byte-level parser: signature check, chunk walk, ihdr capture and verdict
// depends on pngcsv_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pngcsv_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_file,
  output pngcsv_pkg::push_t      push
);

  pngcsv_pkg::phase_t phase, phase_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [31:0] length_shift, length_shift_next;
  logic [31:0] type_shift, type_shift_next;
  logic [32:0] skip_count, skip_count_next;
  logic [1:0]  chunks_after_header, chunks_after_header_next;
  logic        last_type_was_end, last_type_was_end_next;
  logic [2:0]  error_code, error_code_next;
  logic        first_data, first_data_next;
  logic [7:0]  header_fields [pngcsv_pkg::IHDR_LEN];
  logic        field_we;
  logic [2:0]  verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= pngcsv_pkg::PH_SIG;
      byte_position       <= '0;
      length_shift        <= '0;
      type_shift          <= '0;
      skip_count          <= '0;
      chunks_after_header <= '0;
      last_type_was_end   <= 1'b0;
      error_code          <= '0;
      first_data          <= 1'b0;
    end else if (accept) begin
      phase               <= phase_next;
      byte_position       <= byte_position_next;
      length_shift        <= length_shift_next;
      type_shift          <= type_shift_next;
      skip_count          <= skip_count_next;
      chunks_after_header <= chunks_after_header_next;
      last_type_was_end   <= last_type_was_end_next;
      error_code          <= error_code_next;
      first_data          <= first_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && field_we) begin
      header_fields[byte_position] <= data_byte;
    end
  end

  always_comb begin
    phase_next               = phase;
    byte_position_next       = byte_position;
    length_shift_next        = length_shift;
    type_shift_next          = type_shift;
    skip_count_next          = skip_count;
    chunks_after_header_next = chunks_after_header;
    last_type_was_end_next   = last_type_was_end;
    error_code_next          = error_code;
    first_data_next          = first_data;
    field_we                 = 1'b0;
    verdict                  = pngcsv_pkg::ST_OK;
    push                     = '0;

    unique case (phase)
      pngcsv_pkg::PH_SIG: begin
        if (data_byte != pngcsv_pkg::sig_byte(byte_position[2:0])) begin
          error_code_next = pngcsv_pkg::ST_BAD_SIG;
        end
        if (byte_position == 4'd7) begin
          byte_position_next = '0;
          phase_next = (error_code_next != pngcsv_pkg::ST_OK) ?
                       pngcsv_pkg::PH_DONE : pngcsv_pkg::PH_IHDR_HDR;
        end else begin
          byte_position_next = byte_position + 4'd1;
        end
      end
      pngcsv_pkg::PH_IHDR_HDR, pngcsv_pkg::PH_HDR: begin
        if (byte_position < 4'd4) begin
          length_shift_next = {length_shift[23:0], data_byte};
        end else begin
          type_shift_next = {type_shift[23:0], data_byte};
        end
        if (byte_position == 4'd7) begin
          byte_position_next = '0;
          push.a_valid = 1'b1;
          push.a.record_kind  = pngcsv_pkg::KIND_HEADER;
          push.a.chunk_length = length_shift_next;
          push.a.chunk_tag    = type_shift_next;
          if (phase == pngcsv_pkg::PH_IHDR_HDR) begin
            if (type_shift_next != pngcsv_pkg::TYPE_IHDR) begin
              error_code_next = pngcsv_pkg::ST_NO_IHDR;
              phase_next = pngcsv_pkg::PH_DONE;
            end else begin
              phase_next = pngcsv_pkg::PH_IHDR_DATA;
              skip_count_next = {1'b0, length_shift_next} + 33'd4;
              first_data_next = 1'b1;
            end
          end else begin
            if (chunks_after_header != 2'd3) begin
              chunks_after_header_next = chunks_after_header + 2'd1;
            end
            last_type_was_end_next = (type_shift_next == pngcsv_pkg::TYPE_IEND);
            if (last_type_was_end_next) begin
              phase_next = pngcsv_pkg::PH_DONE;
            end else begin
              phase_next = pngcsv_pkg::PH_SKIP;
              skip_count_next = {1'b0, length_shift_next} + 33'd4;
            end
          end
        end else begin
          byte_position_next = byte_position + 4'd1;
        end
      end
      pngcsv_pkg::PH_IHDR_DATA: begin
        first_data_next = 1'b0;
        // header length other than thirteen is flagged on the first data byte
        if (first_data && length_shift != pngcsv_pkg::IHDR_LEN_W) begin
          push.a_valid = 1'b1;
          push.a.record_kind  = pngcsv_pkg::KIND_IHDR;
          push.a.chunk_length = length_shift;
          push.a.chunk_tag    = type_shift;
          push.a.status       = pngcsv_pkg::ST_BAD_IHDR;
        end
        if (skip_count > 33'd4 && byte_position < pngcsv_pkg::IHDR_LEN_POS) begin
          field_we = 1'b1;
          byte_position_next = byte_position + 4'd1;
          if (byte_position == pngcsv_pkg::IHDR_LAST_POS &&
              length_shift == pngcsv_pkg::IHDR_LEN_W) begin
            push.a_valid = 1'b1;
            push.a.record_kind     = pngcsv_pkg::KIND_IHDR;
            push.a.chunk_length    = length_shift;
            push.a.chunk_tag       = type_shift;
            push.a.image_width     = {header_fields[0], header_fields[1],
                                      header_fields[2], header_fields[3]};
            push.a.image_height    = {header_fields[4], header_fields[5],
                                      header_fields[6], header_fields[7]};
            push.a.pixel_depth     = header_fields[8];
            push.a.color_class     = pngcsv_pkg::color_of(header_fields[9]);
            push.a.compression_ok  = (header_fields[10] == 8'd0);
            push.a.filter_ok       = (header_fields[11] == 8'd0);
            // the interlace byte is the one arriving now
            push.a.interlace_class = pngcsv_pkg::interlace_of(data_byte);
          end
        end
        skip_count_next = skip_count - 33'd1;
        if (skip_count == 33'd1) begin
          phase_next = pngcsv_pkg::PH_HDR;
          byte_position_next = '0;
        end
      end
      pngcsv_pkg::PH_SKIP: begin
        skip_count_next = skip_count - 33'd1;
        if (skip_count == 33'd1) begin
          phase_next = pngcsv_pkg::PH_HDR;
          byte_position_next = '0;
        end
      end
      default: begin
      end
    endcase

    if (end_of_file) begin
      if (phase == pngcsv_pkg::PH_SIG) begin
        verdict = pngcsv_pkg::ST_TOO_SMALL;
      end else if (error_code_next != pngcsv_pkg::ST_OK) begin
        verdict = error_code_next;
      end else if (phase_next == pngcsv_pkg::PH_IHDR_HDR ||
                   (phase_next == pngcsv_pkg::PH_HDR && byte_position_next != 4'd0)) begin
        verdict = pngcsv_pkg::ST_TRUNCATED;
      end else if (chunks_after_header_next == 2'd0) begin
        verdict = pngcsv_pkg::ST_NO_DATA;
      end else if (!last_type_was_end_next) begin
        verdict = pngcsv_pkg::ST_NO_IEND;
      end else begin
        verdict = pngcsv_pkg::ST_OK;
      end
      push.b_valid = 1'b1;
      push.b.record_kind = pngcsv_pkg::KIND_VERDICT;
      push.b.status      = verdict;
      push.b.last_of_run = 1'b1;
      // back to the start so the next byte opens a new file
      phase_next               = pngcsv_pkg::PH_SIG;
      byte_position_next       = '0;
      length_shift_next        = '0;
      type_shift_next          = '0;
      skip_count_next          = '0;
      chunks_after_header_next = '0;
      last_type_was_end_next   = 1'b0;
      error_code_next          = '0;
      first_data_next          = 1'b0;
    end else begin
      push.a.last_of_run = push.a_valid;
    end
  end

  `PCV_ASSERT_NXT(a_eof_restart, clk, rst, accept && end_of_file,
    phase == pngcsv_pkg::PH_SIG && byte_position == 4'd0 && error_code == pngcsv_pkg::ST_OK,
    "parser did not restart after end of file")
  `PCV_ASSERT_IMP(a_done_reason, clk, rst, phase == pngcsv_pkg::PH_DONE,
    error_code != pngcsv_pkg::ST_OK || last_type_was_end,
    "walk stopped without an error or an end chunk")

endmodule

`default_nettype wire

### design/pngcsv_queue.sv
// small record queue taking up to two records a cycle and giving one
// depends on pngcsv_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pngcsv_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pngcsv_pkg::push_t   push,
  input  wire logic                push_en,
  input  wire logic                pop,
  output logic                     full_for_two,
  output logic                     head_valid,
  output pngcsv_pkg::rec_t         head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  pngcsv_pkg::rec_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next, wr_ptr_plus;
  logic [CW-1:0] count, count_next;
  logic          wr0, wr1;
  logic [1:0]    push_n;
  pngcsv_pkg::rec_t slot0;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr0         = push_en && (push.a_valid || push.b_valid);
    wr1         = push_en && push.a_valid && push.b_valid;
    push_n      = {1'b0, wr0} + {1'b0, wr1};
    slot0       = push.a_valid ? push.a : push.b;
    wr_ptr_plus = bump(wr_ptr);
    wr_ptr_next = wr1 ? bump(wr_ptr_plus) : (wr0 ? wr_ptr_plus : wr_ptr);
    rd_ptr_next = pop ? bump(rd_ptr) : rd_ptr;
    count_next  = count + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr0) begin
      mem[wr_ptr] <= slot0;
    end
    if (wr1) begin
      mem[wr_ptr_plus] <= push.b;
    end
  end

  assign head_valid   = (count != '0);
  assign head         = mem[rd_ptr];
  assign full_for_two = (count > CW'(DEPTH - 2));

  `PCV_ASSERT(a_no_overflow, clk, rst, count <= CW'(DEPTH),
    "record queue holds more than its depth")
  `PCV_ASSERT_IMP(a_empty_ptrs, clk, rst, count == '0, wr_ptr == rd_ptr,
    "empty record queue with pointers apart")

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for png_chunk_stream_validator_top: whole png files go in
// one byte per request, each record out is checked against an in-bench chunk walker
// depends on pngcsv_pkg and the validator rtl

module tb;

  // png signature, first byte in the top bits
  localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;

  // raw ihdr color type and interlace bytes
  localparam logic [7:0] RAW_GRAY        = 8'd0;
  localparam logic [7:0] RAW_TRUE        = 8'd2;
  localparam logic [7:0] RAW_INDEXED     = 8'd3;
  localparam logic [7:0] RAW_GRAY_ALPHA  = 8'd4;
  localparam logic [7:0] RAW_TRUE_ALPHA  = 8'd6;
  localparam logic [7:0] RAW_BAD_COLOR   = 8'd1;
  localparam logic [7:0] RAW_ILACE_NONE  = 8'd0;
  localparam logic [7:0] RAW_ILACE_ADAM7 = 8'd1;

  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_BYTES  = 60;
  localparam int unsigned DRAIN_CYCLES = 10;

  // one byte request waiting to be driven; hold makes the sender wait for an empty
  // record backlog before presenting it
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       hold;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        end_of_file = 1'b0;
  logic        rec_valid;
  logic        rec_stall = 1'b0;
  logic [1:0]  record_kind;
  logic [31:0] chunk_length;
  logic [31:0] chunk_tag;
  logic [31:0] image_width;
  logic [31:0] image_height;
  logic [7:0]  pixel_depth;
  logic [2:0]  color_class;
  logic [1:0]  interlace_class;
  logic        compression_ok;
  logic        filter_ok;
  logic [2:0]  status;
  logic        last_of_run;

  png_chunk_stream_validator_top dut (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .data_byte       (data_byte),
    .end_of_file     (end_of_file),
    .rec_valid       (rec_valid),
    .rec_stall       (rec_stall),
    .record_kind     (record_kind),
    .chunk_length    (chunk_length),
    .chunk_tag       (chunk_tag),
    .image_width     (image_width),
    .image_height    (image_height),
    .pixel_depth     (pixel_depth),
    .color_class     (color_class),
    .interlace_class (interlace_class),
    .compression_ok  (compression_ok),
    .filter_ok       (filter_ok),
    .status          (status),
    .last_of_run     (last_of_run)
  );

  always #5 clk = ~clk;

  // traffic shaping, percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  byte_req_t   pending_bytes[$];
  byte_req_t   next_req;
  logic [7:0]  file_buf[$];
  int unsigned queued_bytes = 0;

  pngcsv_pkg::rec_t expected_records[$];
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // chunk walker: mirrors the parser state and predicts the records
  // ---------------------------------------------------------------------------
  pngcsv_pkg::phase_t walk_phase = pngcsv_pkg::PH_SIG;
  logic [3:0]  walk_pos = 4'd0;
  logic [31:0] len_acc = 32'd0;
  logic [31:0] type_acc = 32'd0;
  logic [32:0] bytes_left = 33'd0;
  logic [1:0]  chunks_seen = 2'd0;
  logic        ended_on_iend = 1'b0;
  logic [2:0]  file_error = pngcsv_pkg::ST_OK;
  logic [7:0]  ihdr_bytes [0:12];

  task automatic clear_walk();
    walk_phase    = pngcsv_pkg::PH_SIG;
    walk_pos      = 4'd0;
    len_acc       = 32'd0;
    type_acc      = 32'd0;
    bytes_left    = 33'd0;
    chunks_seen   = 2'd0;
    ended_on_iend = 1'b0;
    file_error    = pngcsv_pkg::ST_OK;
  endtask

  function automatic pngcsv_pkg::rec_t blank_rec(input logic [1:0] kind,
                                                 input logic [31:0] len,
                                                 input logic [31:0] typ,
                                                 input logic [2:0] st);
    pngcsv_pkg::rec_t r;
    r = '0;
    r.record_kind  = kind;
    r.chunk_length = len;
    r.chunk_tag    = typ;
    r.status       = st;
    return r;
  endfunction

  function automatic logic [2:0] class_of_color(input logic [7:0] raw);
    case (raw)
      RAW_GRAY:       return pngcsv_pkg::COLOR_GRAY;
      RAW_TRUE:       return pngcsv_pkg::COLOR_TRUE;
      RAW_INDEXED:    return pngcsv_pkg::COLOR_INDEXED;
      RAW_GRAY_ALPHA: return pngcsv_pkg::COLOR_GRAY_ALPHA;
      RAW_TRUE_ALPHA: return pngcsv_pkg::COLOR_TRUE_ALPHA;
      default:        return pngcsv_pkg::COLOR_INVALID;
    endcase
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic eof);
    pngcsv_pkg::rec_t recs[$];
    pngcsv_pkg::rec_t r;
    logic       short_file;
    logic       count_down;
    logic [2:0] verdict;
    short_file = (walk_phase == pngcsv_pkg::PH_SIG);
    count_down = 1'b0;
    case (walk_phase)
      pngcsv_pkg::PH_SIG: begin
        if (b != PNG_MAGIC[63 - 8 * walk_pos[2:0] -: 8]) file_error = pngcsv_pkg::ST_BAD_SIG;
        walk_pos++;
        if (walk_pos >= 4'd8) begin
          walk_pos   = 4'd0;
          walk_phase = (file_error != pngcsv_pkg::ST_OK) ? pngcsv_pkg::PH_DONE
                                                         : pngcsv_pkg::PH_IHDR_HDR;
        end
      end
      pngcsv_pkg::PH_IHDR_HDR, pngcsv_pkg::PH_HDR: begin
        if (walk_pos < 4'd4) len_acc = {len_acc[23:0], b};
        else type_acc = {type_acc[23:0], b};
        walk_pos++;
        if (walk_pos >= 4'd8) begin
          walk_pos = 4'd0;
          recs.push_back(blank_rec(pngcsv_pkg::KIND_HEADER, len_acc, type_acc,
                                   pngcsv_pkg::ST_OK));
          if (walk_phase == pngcsv_pkg::PH_IHDR_HDR) begin
            if (type_acc != pngcsv_pkg::TYPE_IHDR) begin
              file_error = pngcsv_pkg::ST_NO_IHDR;
              walk_phase = pngcsv_pkg::PH_DONE;
            end else begin
              walk_phase = pngcsv_pkg::PH_IHDR_DATA;
              bytes_left = {1'b0, len_acc} + 33'd4;
            end
          end else begin
            if (chunks_seen != 2'd3) chunks_seen++;
            ended_on_iend = (type_acc == pngcsv_pkg::TYPE_IEND);
            if (ended_on_iend) begin
              walk_phase = pngcsv_pkg::PH_DONE;
            end else begin
              walk_phase = pngcsv_pkg::PH_SKIP;
              bytes_left = {1'b0, len_acc} + 33'd4;
            end
          end
        end
      end
      pngcsv_pkg::PH_IHDR_DATA: begin
        // ihdr length other than thirteen is flagged on the first data byte
        if (bytes_left == {1'b0, len_acc} + 33'd4 && len_acc != pngcsv_pkg::IHDR_LEN_W)
          recs.push_back(blank_rec(pngcsv_pkg::KIND_IHDR, len_acc, type_acc,
                                   pngcsv_pkg::ST_BAD_IHDR));
        if (bytes_left > 33'd4 && walk_pos < pngcsv_pkg::IHDR_LEN_POS) begin
          ihdr_bytes[walk_pos] = b;
          walk_pos++;
          if (walk_pos == pngcsv_pkg::IHDR_LEN_POS && len_acc == pngcsv_pkg::IHDR_LEN_W) begin
            r = blank_rec(pngcsv_pkg::KIND_IHDR, len_acc, type_acc, pngcsv_pkg::ST_OK);
            r.image_width     = {ihdr_bytes[0], ihdr_bytes[1], ihdr_bytes[2], ihdr_bytes[3]};
            r.image_height    = {ihdr_bytes[4], ihdr_bytes[5], ihdr_bytes[6], ihdr_bytes[7]};
            r.pixel_depth     = ihdr_bytes[8];
            r.color_class     = class_of_color(ihdr_bytes[9]);
            r.interlace_class = (ihdr_bytes[12] == RAW_ILACE_NONE)  ? pngcsv_pkg::ILACE_NONE :
                                (ihdr_bytes[12] == RAW_ILACE_ADAM7) ? pngcsv_pkg::ILACE_ADAM7 :
                                pngcsv_pkg::ILACE_INVALID;
            r.compression_ok  = (ihdr_bytes[10] == 8'd0);
            r.filter_ok       = (ihdr_bytes[11] == 8'd0);
            recs.push_back(r);
          end
        end
        count_down = 1'b1;
      end
      pngcsv_pkg::PH_SKIP: count_down = 1'b1;
      default: ;
    endcase

    // data plus crc countdown, shared by ihdr data and skipped chunks
    if (count_down) begin
      if (bytes_left != 33'd0) bytes_left--;
      if (bytes_left == 33'd0) begin
        walk_phase = pngcsv_pkg::PH_HDR;
        walk_pos   = 4'd0;
      end
    end

    if (eof) begin
      if (short_file) verdict = pngcsv_pkg::ST_TOO_SMALL;
      else if (file_error != pngcsv_pkg::ST_OK) verdict = file_error;
      else if (walk_phase == pngcsv_pkg::PH_IHDR_HDR ||
               (walk_phase == pngcsv_pkg::PH_HDR && walk_pos != 4'd0))
        verdict = pngcsv_pkg::ST_TRUNCATED;
      else if (chunks_seen == 2'd0) verdict = pngcsv_pkg::ST_NO_DATA;
      else if (!ended_on_iend) verdict = pngcsv_pkg::ST_NO_IEND;
      else verdict = pngcsv_pkg::ST_OK;
      recs.push_back(blank_rec(pngcsv_pkg::KIND_VERDICT, 32'd0, 32'd0, verdict));
      clear_walk();
    end

    if (recs.size() != 0) begin
      r = recs.pop_back();
      r.last_of_run = 1'b1;
      recs.push_back(r);
    end
    foreach (recs[i]) expected_records.push_back(recs[i]);
  endtask

  // ---------------------------------------------------------------------------
  // file building
  // ---------------------------------------------------------------------------
  task automatic put_word(input logic [31:0] v);
    file_buf.push_back(v[31:24]);
    file_buf.push_back(v[23:16]);
    file_buf.push_back(v[15:8]);
    file_buf.push_back(v[7:0]);
  endtask

  // bad_at of 8 or more keeps the signature intact
  task automatic put_magic(input int unsigned bad_at);
    logic [7:0] v;
    for (int i = 0; i < 8; i++) begin
      v = PNG_MAGIC[63 - 8 * i -: 8];
      if (i == bad_at) v = v ^ 8'($urandom_range(1, 255));
      file_buf.push_back(v);
    end
  endtask

  task automatic put_header(input logic [31:0] len, input logic [31:0] typ);
    put_word(len);
    put_word(typ);
  endtask

  // complete chunk with random data and crc bytes
  task automatic put_chunk(input logic [31:0] len, input logic [31:0] typ);
    put_header(len, typ);
    repeat (len + 4) file_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_ihdr(input logic [31:0] w, input logic [31:0] h, input logic [7:0] depth,
                          input logic [7:0] color, input logic [7:0] comp,
                          input logic [7:0] filt, input logic [7:0] il);
    put_header(pngcsv_pkg::IHDR_LEN_W, pngcsv_pkg::TYPE_IHDR);
    put_word(w);
    put_word(h);
    file_buf.push_back(depth);
    file_buf.push_back(color);
    file_buf.push_back(comp);
    file_buf.push_back(filt);
    file_buf.push_back(il);
    put_word($urandom());
  endtask

  // 0..4 legal color types, 5 an illegal one, anything else a random byte
  function automatic logic [7:0] pick_color(input int unsigned idx);
    case (idx)
      0:       return RAW_GRAY;
      1:       return RAW_TRUE;
      2:       return RAW_INDEXED;
      3:       return RAW_GRAY_ALPHA;
      4:       return RAW_TRUE_ALPHA;
      5:       return RAW_BAD_COLOR;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // move the built file into the request queue, end_of_file on its last byte
  task automatic ship_file(input logic hold);
    byte_req_t req;
    foreach (file_buf[i]) begin
      req.value = file_buf[i];
      req.last  = (i == file_buf.size() - 1);
      req.hold  = hold && (i == 0);
      pending_bytes.push_back(req);
    end
    queued_bytes += file_buf.size();
    file_buf.delete();
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: presents the next request once the current one is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      byte_valid  <= 1'b0;
      data_byte   <= 8'd0;
      end_of_file <= 1'b0;
    end else begin
      // request taken at this edge: predict its records before choosing the next
      if (byte_valid && !byte_stall) predict_byte(data_byte, end_of_file);
      if (!byte_valid || !byte_stall) begin
        if (pending_bytes.size() != 0 &&
            !(pending_bytes[0].hold && expected_records.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          next_req     = pending_bytes.pop_front();
          byte_valid  <= 1'b1;
          data_byte   <= next_req.value;
          end_of_file <= next_req.last;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // record monitor and receiver stall
  // ---------------------------------------------------------------------------
  function automatic string fmt_rec(input pngcsv_pkg::rec_t r);
    string front;
    string back;
    front = $sformatf("kind=%0d len=%h tag=%h w=%h h=%h depth=%h ",
                      r.record_kind, r.chunk_length, r.chunk_tag, r.image_width,
                      r.image_height, r.pixel_depth);
    back  = $sformatf("color=%0d il=%0d comp=%b filt=%b st=%0d last=%b",
                      r.color_class, r.interlace_class, r.compression_ok,
                      r.filter_ok, r.status, r.last_of_run);
    return {front, back};
  endfunction

  task automatic check_record();
    pngcsv_pkg::rec_t got;
    pngcsv_pkg::rec_t want;
    got.record_kind     = record_kind;
    got.chunk_length    = chunk_length;
    got.chunk_tag       = chunk_tag;
    got.image_width     = image_width;
    got.image_height    = image_height;
    got.pixel_depth     = pixel_depth;
    got.color_class     = color_class;
    got.interlace_class = interlace_class;
    got.compression_ok  = compression_ok;
    got.filter_ok       = filter_ok;
    got.status          = status;
    got.last_of_run     = last_of_run;
    if (expected_records.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: record with nothing pending: %s", $realtime, fmt_rec(got));
    end else begin
      want = expected_records.pop_front();
      if (got.record_kind !== want.record_kind || got.chunk_length !== want.chunk_length ||
          got.chunk_tag !== want.chunk_tag || got.image_width !== want.image_width ||
          got.image_height !== want.image_height || got.pixel_depth !== want.pixel_depth ||
          got.color_class !== want.color_class ||
          got.interlace_class !== want.interlace_class ||
          got.compression_ok !== want.compression_ok || got.filter_ok !== want.filter_ok ||
          got.status !== want.status || got.last_of_run !== want.last_of_run) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: record mismatch", $realtime);
          $display("  want %s", fmt_rec(want));
          $display("  got  %s", fmt_rec(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rec_stall <= 1'b0;
    end else begin
      if (rec_valid && !rec_stall) check_record();
      rec_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: cycles with work outstanding but no request taken on either side
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (rec_valid && !rec_stall) ||
        (pending_bytes.size() == 0 && expected_records.size() == 0 && !byte_valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("png_chunk_stream_validator_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed files, then four traffic phases of random files
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned roll;
    int unsigned n_mid;
    int unsigned keep;
    int unsigned files;
    int unsigned phase_start;
    logic        cut;

    // one-byte file and a bare signature are both too small
    file_buf.push_back(8'hFF);
    ship_file(1'b1);
    put_magic(8);
    ship_file(1'b0);
    // one byte past the signature cuts the ihdr header
    put_magic(8);
    file_buf.push_back(8'h00);
    ship_file(1'b0);
    // corrupted signature byte, rest well formed
    put_magic(3);
    put_ihdr(32'd1, 32'd1, 8'd8, RAW_GRAY, 8'd0, 8'd0, RAW_ILACE_NONE);
    put_chunk(32'd0, pngcsv_pkg::TYPE_IEND);
    ship_file(1'b0);
    // first chunk is not ihdr
    put_magic(8);
    put_chunk(32'd2, TYPE_IDAT);
    ship_file(1'b0);
    // clean file with extreme ihdr fields and trailing bytes after iend
    put_magic(8);
    put_ihdr(32'hFFFF_FFFF, 32'd0, 8'hFF, RAW_TRUE_ALPHA, 8'd0, 8'd0, RAW_ILACE_ADAM7);
    put_chunk(32'd0, TYPE_IDAT);
    put_chunk(32'd0, pngcsv_pkg::TYPE_IEND);
    repeat (3) file_buf.push_back(8'($urandom_range(255)));
    ship_file(1'b0);
    // ihdr alone: no data chunks
    put_magic(8);
    put_ihdr(32'd0, 32'hFFFF_FFFF, 8'd0, RAW_GRAY, 8'd0, 8'd0, RAW_ILACE_NONE);
    ship_file(1'b0);
    // data but no iend
    put_magic(8);
    put_ihdr(32'h8000_0001, 32'h7FFF_FFFE, 8'd16, RAW_INDEXED, 8'd0, 8'd0, RAW_ILACE_NONE);
    put_chunk(32'd5, TYPE_IDAT);
    ship_file(1'b0);
    // ihdr of length zero and of length five, walk goes on
    put_magic(8);
    put_chunk(32'd0, pngcsv_pkg::TYPE_IHDR);
    put_chunk(32'd0, pngcsv_pkg::TYPE_IEND);
    ship_file(1'b0);
    put_magic(8);
    put_chunk(32'd5, pngcsv_pkg::TYPE_IHDR);
    put_chunk(32'd20, TYPE_IDAT);
    put_chunk(32'd0, pngcsv_pkg::TYPE_IEND);
    ship_file(1'b0);
    // file ends on the last ihdr header byte
    put_magic(8);
    put_header(pngcsv_pkg::IHDR_LEN_W, pngcsv_pkg::TYPE_IHDR);
    ship_file(1'b0);
    // huge ihdr length, data cut short
    put_magic(8);
    put_header(32'hFFFF_FFFF, pngcsv_pkg::TYPE_IHDR);
    repeat (6) file_buf.push_back(8'($urandom_range(255)));
    ship_file(1'b0);
    // ihdr data cut short by end of file
    put_magic(8);
    put_header(pngcsv_pkg::IHDR_LEN_W, pngcsv_pkg::TYPE_IHDR);
    repeat (7) file_buf.push_back(8'($urandom_range(255)));
    ship_file(1'b0);
    // chunk header after ihdr cut in its length field
    put_magic(8);
    put_ihdr(32'd7, 32'd9, 8'd4, RAW_GRAY_ALPHA, 8'd0, 8'd0, RAW_ILACE_NONE);
    file_buf.push_back(8'h00);
    file_buf.push_back(8'h00);
    ship_file(1'b0);
    // every color type and interlace kind, plus bad compression and filter bytes
    for (int i = 0; i < 6; i++) begin
      put_magic(8);
      put_ihdr($urandom(), $urandom(), 8'd8, pick_color(i),
               (i == 4) ? 8'hFF : 8'd0, (i == 5) ? 8'h80 : 8'd0,
               (i % 3 == 0) ? RAW_ILACE_NONE : (i % 3 == 1) ? RAW_ILACE_ADAM7 : 8'hFF);
      put_chunk(32'd1, TYPE_IDAT);
      put_chunk(32'd0, pngcsv_pkg::TYPE_IEND);
      ship_file(1'b0);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      // free flow, idle sender, stalling receiver, then both
      send_idle_pct = (p == 1) ? 75 : (p == 3) ? 30 : 0;
      stall_pct     = (p == 2) ? 75 : (p == 3) ? 30 : 0;
      phase_start   = queued_bytes;
      files         = 0;
      while (queued_bytes - phase_start < PHASE_BYTES) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          // noise file
          repeat ($urandom_range(1, 24)) file_buf.push_back(8'($urandom_range(255)));
        end else begin
          put_magic(($urandom_range(99) < 6) ? $urandom_range(7) : 8);
          cut  = 1'b0;
          roll = $urandom_range(99);
          if (roll < 78) begin
            put_ihdr(($urandom_range(1) != 0) ? $urandom() : $urandom_range(1, 4096),
                     ($urandom_range(1) != 0) ? $urandom() : $urandom_range(1, 4096),
                     ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                              : 8'(8'd1 << $urandom_range(0, 4)),
                     pick_color($urandom_range(0, 6)),
                     ($urandom_range(99) < 85) ? 8'd0 : 8'($urandom_range(255)),
                     ($urandom_range(99) < 85) ? 8'd0 : 8'($urandom_range(255)),
                     ($urandom_range(2) == 2) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(1)));
          end else if (roll < 88) begin
            put_chunk($urandom_range(0, 20), pngcsv_pkg::TYPE_IHDR);
          end else if (roll < 94) begin
            put_chunk($urandom_range(0, 8), $urandom());
          end else begin
            // oversized ihdr, file ends inside it
            put_header($urandom(), pngcsv_pkg::TYPE_IHDR);
            repeat ($urandom_range(0, 20)) file_buf.push_back(8'($urandom_range(255)));
            cut = 1'b1;
          end
          n_mid = cut ? 0 : $urandom_range(0, 3);
          repeat (n_mid) begin
            if (!cut) begin
              if ($urandom_range(99) < 10) begin
                // random length up to 32 bits, file ends in the data
                put_header($urandom(), TYPE_IDAT);
                repeat ($urandom_range(0, 6)) file_buf.push_back(8'($urandom_range(255)));
                cut = 1'b1;
              end else begin
                put_chunk($urandom_range(0, 16),
                          ($urandom_range(1) != 0) ? TYPE_IDAT : $urandom());
              end
            end
          end
          if (!cut && $urandom_range(99) < 85) begin
            put_chunk(32'd0, pngcsv_pkg::TYPE_IEND);
            if ($urandom_range(99) < 15)
              repeat ($urandom_range(1, 6)) file_buf.push_back(8'($urandom_range(255)));
          end
          // some files end at a random point
          if ($urandom_range(99) < 10) begin
            keep = $urandom_range(1, file_buf.size());
            while (file_buf.size() > keep) void'(file_buf.pop_back());
          end
        end
        // every so often the sender waits for the record backlog to drain
        ship_file(files % 16 == 0);
        files++;
      end
      while (pending_bytes.size() != 0) @(posedge clk);
    end

    while (byte_valid || expected_records.size() != 0) @(posedge clk);
    // catch any extra record after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("png_chunk_stream_validator_top regression: pass");
    end else begin
      $display("png_chunk_stream_validator_top regression: fail");
    end
    $finish;
  end

endmodule
